>>> hdl/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types and constants of the beacon clock discipline core.
// ----------------------------------------------------------------------------
`default_nettype none

package bcd_pkg;

   localparam int AVG_DEPTH_DEF = 10;

   localparam logic [15:0] CRC_POLY       = 16'h1021;
   localparam logic [32:0] JUMP_LIMIT     = 33'd30000000;
   localparam logic [49:0] PERIOD_MAX     = 50'd480000000;
   localparam logic [28:0] INIT_PERIOD_RST = 29'd48000000;

   localparam int DVD_W   = 50;
   localparam int DVS_W   = 17;
   localparam int LAT_W   = 20;
   localparam int PER_W   = 29;
   localparam int CSR_W   = 29;

   localparam logic CSR_LATENCY_OFFSET = 1'b0;
   localparam logic CSR_INITIAL_PERIOD = 1'b1;

   localparam logic [1:0] PHASE_START = 2'd0;
   localparam logic [1:0] PHASE_SYNC  = 2'd1;
   localparam logic [1:0] PHASE_TRIM  = 2'd2;

   localparam logic [1:0] BAD_NONE  = 2'd0;
   localparam logic [1:0] BAD_LATE  = 2'd1;
   localparam logic [1:0] BAD_EARLY = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE, S_CRC, S_CHECK, S_DECIDE, S_FIRST, S_MUL1, S_OFFS, S_LATE,
      S_EARLY, S_MUL2, S_TICKS, S_NOM_SEL, S_NOM_WAIT, S_NOM, S_SUM,
      S_AVG_START, S_AVG_WAIT, S_AVG, S_TRIM_SEL, S_TRIM_WAIT, S_TRIM,
      S_SYNC, S_COMMIT, S_EMIT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_CRC, OP_CHECK, OP_FIRST, OP_MUL1, OP_OFFS,
      OP_LATE, OP_EARLY, OP_MUL2, OP_TICKS, OP_NOM_AVG, OP_DIV_NOM, OP_NOM,
      OP_SUM, OP_DIV_AVG, OP_AVG, OP_TRIM0, OP_DIV_TRIM, OP_TRIM, OP_SYNC,
      OP_COMMIT, OP_EMIT
   } op_type;

   typedef struct packed {
      logic crc_last;
      logic ok;
      logic phase_zero;
      logic phase_ge2;
      logic secs_zero;
      logic ticks_neg;
      logic div_done;
   } dp_status_type;

endpackage

`default_nettype wire

>>> hdl/bcd_ram.sv
// ----------------------------------------------------------------------------
// bcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_ram #(
   parameter int WIDTH = 29,
   parameter int DEPTH = 10,
   parameter int AW    = 4
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

>>> hdl/bcd_div.sv
// ----------------------------------------------------------------------------
// bcd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_div #(
   parameter int DVD_W = 50,
   parameter int DVS_W = 17
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic      [DVD_W-1:0] quotient
);

   localparam int CW = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DVD_W-1:0] num_ff, num_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] den_ff, den_in;
   logic [DVS_W:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, num_ff[DVD_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DVD_W);
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DVS_W'(trial - {1'b0, den_ff}) : trial[DVS_W-1:0];
         num_in = {num_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

`default_nettype wire

>>> hdl/bcd_ctrl.sv
// ----------------------------------------------------------------------------
// bcd_ctrl
// Sequencer: steps the datapath through one request and runs the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire bcd_pkg::dp_status_type status,
   output bcd_pkg::op_type            op
);

   import bcd_pkg::*;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op        = OP_NONE;
      req_ready = 1'b0;
      valid_in  = (valid_ff && rsp_ready) ? 1'b0 : valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = S_CRC;
            end
         end
         S_CRC: begin
            op = OP_CRC;
            if (status.crc_last) state_in = S_CHECK;
         end
         S_CHECK: begin
            op       = OP_CHECK;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            priority if (!status.ok) state_in = S_EMIT;
            else if (status.phase_zero) state_in = S_FIRST;
            else state_in = S_MUL1;
         end
         S_FIRST: begin
            op       = OP_FIRST;
            state_in = S_COMMIT;
         end
         S_MUL1: begin
            op       = OP_MUL1;
            state_in = S_OFFS;
         end
         S_OFFS: begin
            op       = OP_OFFS;
            state_in = S_LATE;
         end
         S_LATE: begin
            op       = OP_LATE;
            state_in = S_EARLY;
         end
         S_EARLY: begin
            op       = OP_EARLY;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            op       = OP_MUL2;
            state_in = S_TICKS;
         end
         S_TICKS: begin
            op       = OP_TICKS;
            state_in = S_NOM_SEL;
         end
         S_NOM_SEL: begin
            if (status.secs_zero || status.ticks_neg) begin
               op       = OP_NOM_AVG;
               state_in = S_SUM;
            end else begin
               op       = OP_DIV_NOM;
               state_in = S_NOM_WAIT;
            end
         end
         S_NOM_WAIT: begin
            if (status.div_done) state_in = S_NOM;
         end
         S_NOM: begin
            op       = OP_NOM;
            state_in = S_SUM;
         end
         S_SUM: begin
            op       = OP_SUM;
            state_in = S_AVG_START;
         end
         S_AVG_START: begin
            op       = OP_DIV_AVG;
            state_in = S_AVG_WAIT;
         end
         S_AVG_WAIT: begin
            if (status.div_done) state_in = S_AVG;
         end
         S_AVG: begin
            op       = OP_AVG;
            state_in = S_TRIM_SEL;
         end
         S_TRIM_SEL: begin
            priority if (!status.phase_ge2) begin
               state_in = S_SYNC;
            end else if (status.secs_zero) begin
               op       = OP_TRIM0;
               state_in = S_COMMIT;
            end else begin
               op       = OP_DIV_TRIM;
               state_in = S_TRIM_WAIT;
            end
         end
         S_TRIM_WAIT: begin
            if (status.div_done) state_in = S_TRIM;
         end
         S_TRIM: begin
            op       = OP_TRIM;
            state_in = S_COMMIT;
         end
         S_SYNC: begin
            op       = OP_SYNC;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            op       = OP_COMMIT;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // hold until the output register is free
            if (!valid_ff || rsp_ready) begin
               op       = OP_EMIT;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

>>> hdl/bcd_dp.sv
// ----------------------------------------------------------------------------
// bcd_dp
// Datapath: CRC, offset and period arithmetic, period ring, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_dp #(
   parameter int AVG_DEPTH = bcd_pkg::AVG_DEPTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bcd_pkg::op_type             op,
   output bcd_pkg::dp_status_type           status,
   input  wire logic                        csr_we,
   input  wire logic                        csr_index,
   input  wire logic [bcd_pkg::CSR_W-1:0]   csr_wdata,
   input  wire logic [31:0]                 req_time_bytes,
   input  wire logic [15:0]                 req_crc_received,
   input  wire logic [31:0]                 req_capture_ticks,
   input  wire logic [31:0]                 req_local_seconds,
   input  wire logic [31:0]                 req_second_start_ticks,
   output logic                             rsp_accepted,
   output logic [1:0]                       rsp_bad_stamp,
   output logic signed [31:0]               rsp_phase_offset,
   output logic [28:0]                      rsp_nominal_period,
   output logic [28:0]                      rsp_average_period,
   output logic [31:0]                      rsp_timer_period,
   output logic                             rsp_start_compare,
   output logic                             rsp_counter_reset,
   output logic [31:0]                      rsp_compare_value,
   output logic                             rsp_load_seconds,
   output logic [31:0]                      rsp_new_seconds
);

   import bcd_pkg::*;

   localparam int PW    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int SUM_W = PER_W + $clog2(AVG_DEPTH);
   localparam logic [PW-1:0] PTR_RST  = PW'(65535 % AVG_DEPTH);
   localparam logic [PW-1:0] PTR_LAST = PW'(AVG_DEPTH - 1);
   localparam logic [15:0]   DEPTH16  = 16'(AVG_DEPTH);

   // configuration and block state
   logic [LAT_W-1:0] lat_ff;
   logic [31:0]      cur_ff;
   logic [1:0]       phase_ff;
   logic [15:0]      last_crc_ff;
   logic [31:0]      prev_stamp_ff;
   logic [31:0]      prev_secs_ff;
   logic [31:0]      prev_off_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [PER_W-1:0] avg_ff;
   logic [15:0]      count_ff;
   logic [PW-1:0]    ptr_ff;
   logic [AVG_DEPTH-1:0] valid_ff;

   // per-request working registers
   logic [31:0]      bytes_ff;
   logic [15:0]      crc_rx_ff;
   logic [31:0]      stamp_ff;
   logic [31:0]      local_ff;
   logic [31:0]      second_base_ff;
   logic [15:0]      crc_ff;
   logic [4:0]       bit_ff;
   logic             ok_ff;
   logic [47:0]      prod_ff;
   logic [31:0]      offs_ff;
   logic [15:0]      secs_ff;
   logic [DVD_W-1:0] ticks_ff;
   logic [PER_W-1:0] nom_ff;

   // staged result
   logic             res_accepted_ff;
   logic [1:0]       res_bad_ff;
   logic [31:0]      res_offs_ff;
   logic [PER_W-1:0] res_nom_ff;
   logic [PER_W-1:0] res_avg_ff;
   logic             res_start_ff;
   logic             res_creset_ff;
   logic [31:0]      res_compare_ff;
   logic             res_load_ff;
   logic [31:0]      res_new_ff;

   // combinational helpers
   logic             crc_bit, crc_fb;
   logic [15:0]      crc_next;
   logic [31:0]      mul_a;
   logic [63:0]      mul_full;
   logic [15:0]      secs_now;
   logic [32:0]      jump_diff;
   logic             is_late, is_early;
   logic [31:0]      off_adj;
   logic [31:0]      corr;
   logic [DVD_W-1:0] ticks_calc;
   logic [DVD_W-1:0] ticks_rnd;
   logic             div_start, div_done;
   logic [DVD_W-1:0] div_dvd, div_quot;
   logic [DVS_W-1:0] div_dvs;
   logic [15:0]      avg_div;
   logic [PER_W-1:0] ring_rd, ring_old;
   logic [31:0]      off_abs, trim;

   assign crc_bit  = bytes_ff[{bit_ff[4:3], ~bit_ff[2:0]}];
   assign crc_fb   = crc_ff[15] ^ crc_bit;
   assign crc_next = {crc_ff[14:0], 1'b0} ^ (crc_fb ? CRC_POLY : 16'h0000);

   assign secs_now = 16'(bytes_ff - prev_secs_ff);
   assign mul_a    = (op == OP_MUL1) ? (local_ff - bytes_ff) : {16'h0000, secs_now};
   assign mul_full = mul_a * cur_ff;

   assign jump_diff = {offs_ff[31], offs_ff} - {prev_off_ff[31], prev_off_ff};
   assign is_late   = $signed(jump_diff) > $signed(JUMP_LIMIT);
   assign is_early  = $signed(jump_diff) < -$signed(JUMP_LIMIT);
   assign off_adj   = (op == OP_LATE) ? (offs_ff - cur_ff) : (offs_ff + cur_ff);

   assign corr       = stamp_ff - prev_stamp_ff - prod_ff[31:0];
   assign ticks_calc = {2'b00, prod_ff} + {{(DVD_W-32){corr[31]}}, corr};
   // rounded dividend; a negative sum skips the division and takes the average period
   assign ticks_rnd  = ticks_ff + DVD_W'(secs_ff[15:1]);

   assign avg_div  = ((count_ff == 16'd0) || (count_ff >= DEPTH16)) ? DEPTH16 : count_ff;
   assign ring_old = valid_ff[ptr_ff] ? ring_rd : '0;
   assign off_abs  = offs_ff[31] ? (32'd0 - offs_ff) : offs_ff;
   assign trim     = offs_ff[31] ? (32'd0 - div_quot[31:0]) : div_quot[31:0];

   always_comb begin
      div_start = 1'b0;
      div_dvd   = '0;
      div_dvs   = '0;
      unique case (op)
         OP_DIV_NOM: begin
            div_start = 1'b1;
            div_dvd   = ticks_rnd;
            div_dvs   = {1'b0, secs_ff};
         end
         OP_DIV_AVG: begin
            div_start = 1'b1;
            div_dvd   = DVD_W'(sum_ff);
            div_dvs   = {1'b0, avg_div};
         end
         OP_DIV_TRIM: begin
            div_start = 1'b1;
            div_dvd   = DVD_W'(off_abs);
            div_dvs   = {secs_ff, 1'b0};
         end
         default: ;
      endcase
   end

   bcd_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dvd),
      .divisor (div_dvs),
      .done    (div_done),
      .quotient(div_quot)
   );

   bcd_ram #(.WIDTH(PER_W), .DEPTH(AVG_DEPTH), .AW(PW)) u_ring (
      .clock(clock),
      .we   (op == OP_SUM),
      .waddr(ptr_ff),
      .wdata(nom_ff),
      .raddr(ptr_ff),
      .rdata(ring_rd)
   );

   // block state
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff        <= '0;
         cur_ff        <= 32'(INIT_PERIOD_RST);
         phase_ff      <= PHASE_START;
         last_crc_ff   <= '0;
         prev_stamp_ff <= '0;
         prev_secs_ff  <= '0;
         prev_off_ff   <= '0;
         sum_ff        <= '0;
         avg_ff        <= '0;
         count_ff      <= '0;
         ptr_ff        <= PTR_RST;
         valid_ff      <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_LATENCY_OFFSET: lat_ff <= csr_wdata[LAT_W-1:0];
               CSR_INITIAL_PERIOD: begin
                  if (phase_ff < PHASE_TRIM) cur_ff <= 32'(csr_wdata);
               end
               default: ;
            endcase
         end
         unique case (op)
            OP_CHECK: last_crc_ff <= crc_ff;
            OP_FIRST: phase_ff <= PHASE_SYNC;
            OP_EARLY: begin
               prev_off_ff <= is_early ? off_adj : offs_ff;
               if (is_early) phase_ff <= PHASE_SYNC;
            end
            OP_SUM: begin
               sum_ff <= sum_ff - SUM_W'(ring_old) + SUM_W'(nom_ff);
               valid_ff[ptr_ff] <= 1'b1;
            end
            OP_AVG:   avg_ff <= div_quot[PER_W-1:0];
            OP_TRIM0: cur_ff <= 32'(avg_ff);
            OP_TRIM:  cur_ff <= 32'(avg_ff) + trim;
            OP_SYNC: begin
               cur_ff   <= 32'(avg_ff);
               phase_ff <= PHASE_TRIM;
            end
            OP_COMMIT: begin
               prev_stamp_ff <= stamp_ff;
               prev_secs_ff  <= bytes_ff;
               count_ff      <= count_ff + 16'd1;
               // ring slot follows (count - 1) mod depth
               priority if (count_ff == 16'd0) ptr_ff <= '0;
               else if (ptr_ff == PTR_LAST) ptr_ff <= '0;
               else ptr_ff <= ptr_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // per-request work and staged result
   always_ff @(posedge clock) begin
      unique case (op)
         OP_LOAD: begin
            bytes_ff        <= req_time_bytes;
            crc_rx_ff       <= req_crc_received;
            stamp_ff        <= req_capture_ticks;
            local_ff        <= req_local_seconds;
            second_base_ff  <= req_second_start_ticks;
            crc_ff          <= '0;
            bit_ff          <= '0;
            res_accepted_ff <= 1'b0;
            res_bad_ff      <= BAD_NONE;
            res_offs_ff     <= '0;
            res_nom_ff      <= '0;
            res_avg_ff      <= '0;
            res_start_ff    <= 1'b0;
            res_creset_ff   <= 1'b0;
            res_compare_ff  <= '0;
            res_load_ff     <= 1'b0;
            res_new_ff      <= '0;
         end
         OP_CRC: begin
            crc_ff <= crc_next;
            bit_ff <= bit_ff + 1'b1;
         end
         OP_CHECK: ok_ff <= (crc_ff == crc_rx_ff) && (crc_ff != last_crc_ff);
         OP_FIRST: begin
            res_start_ff <= 1'b1;
            res_load_ff  <= 1'b1;
            res_new_ff   <= bytes_ff;
         end
         OP_MUL1: prod_ff <= mul_full[47:0];
         OP_OFFS: offs_ff <= stamp_ff - second_base_ff + prod_ff[31:0] - 32'(lat_ff);
         OP_LATE: begin
            if (is_late) begin
               stamp_ff   <= stamp_ff - cur_ff;
               offs_ff    <= off_adj;
               res_bad_ff <= BAD_LATE;
            end
         end
         OP_EARLY: begin
            if (is_early) begin
               stamp_ff    <= stamp_ff + cur_ff;
               offs_ff     <= off_adj;
               res_bad_ff  <= BAD_EARLY;
               res_offs_ff <= off_adj;
            end else begin
               res_offs_ff <= offs_ff;
            end
         end
         OP_MUL2: begin
            prod_ff <= mul_full[47:0];
            secs_ff <= secs_now;
         end
         OP_TICKS: ticks_ff <= ticks_calc;
         OP_NOM_AVG: begin
            nom_ff     <= avg_ff;
            res_nom_ff <= avg_ff;
         end
         OP_NOM: begin
            nom_ff     <= (div_quot > PERIOD_MAX) ? avg_ff : div_quot[PER_W-1:0];
            res_nom_ff <= (div_quot > PERIOD_MAX) ? avg_ff : div_quot[PER_W-1:0];
         end
         OP_SYNC: begin
            stamp_ff       <= '0;
            res_creset_ff  <= 1'b1;
            res_compare_ff <= 32'(avg_ff) - 32'(lat_ff);
            res_load_ff    <= 1'b1;
            res_new_ff     <= bytes_ff;
         end
         OP_COMMIT: begin
            res_accepted_ff <= 1'b1;
            res_avg_ff      <= avg_ff;
         end
         OP_EMIT: begin
            rsp_accepted       <= res_accepted_ff;
            rsp_bad_stamp      <= res_bad_ff;
            rsp_phase_offset   <= res_offs_ff;
            rsp_nominal_period <= res_nom_ff;
            rsp_average_period <= res_avg_ff;
            rsp_timer_period   <= cur_ff;
            rsp_start_compare  <= res_start_ff;
            rsp_counter_reset  <= res_creset_ff;
            rsp_compare_value  <= res_compare_ff;
            rsp_load_seconds   <= res_load_ff;
            rsp_new_seconds    <= res_new_ff;
         end
         default: ;
      endcase
   end

   assign status.crc_last   = (bit_ff == 5'd31);
   assign status.ok         = ok_ff;
   assign status.phase_zero = (phase_ff == PHASE_START);
   assign status.phase_ge2  = (phase_ff >= PHASE_TRIM);
   assign status.secs_zero  = (secs_ff == 16'd0);
   assign status.ticks_neg  = ticks_rnd[DVD_W-1];
   assign status.div_done   = div_done;

endmodule

`default_nettype wire

>>> hdl/beacon_clock_discipline_core.sv
// ----------------------------------------------------------------------------
// beacon_clock_discipline_core
// Disciplines a local tick counter to received time beacons.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received beacon (time bytes, CRC, captured tick count,
//   local second count, start tick of that second). rsp_* returns one result
//   per request: accept flag, stamp check, phase offset, measured and average
//   period, the period now in force and the counter commands to apply.
//   csr_* writes latency_offset (index 0) and initial_period (index 1); write
//   them only while the block is idle, as the block does not enforce it.
// Flow:
//   A request runs a bit-serial CRC and then, unless it is rejected or is the
//   first beacon, up to three passes of the shared divider. One request is in
//   work at a time; the block is ready for the next one in the cycle after
//   handing a result.
// Reset clears control and block state, not rsp_* data; the period ring reads
//   as zero until written and the period in force returns to 48000000.
// A stalled receiver holds the result in the output register; the next
//   request is taken and worked meanwhile, waiting only to hand its result.
// ----------------------------------------------------------------------------
`default_nettype none

module beacon_clock_discipline_core #(
   parameter int AVG_DEPTH = bcd_pkg::AVG_DEPTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic                      csr_index,
   input  wire logic [bcd_pkg::CSR_W-1:0] csr_wdata,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [31:0]               req_time_bytes,
   input  wire logic [15:0]               req_crc_received,
   input  wire logic [31:0]               req_capture_ticks,
   input  wire logic [31:0]               req_local_seconds,
   input  wire logic [31:0]               req_second_start_ticks,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_accepted,
   output logic [1:0]                     rsp_bad_stamp,
   output logic signed [31:0]             rsp_phase_offset,
   output logic [28:0]                    rsp_nominal_period,
   output logic [28:0]                    rsp_average_period,
   output logic [31:0]                    rsp_timer_period,
   output logic                           rsp_start_compare,
   output logic                           rsp_counter_reset,
   output logic [31:0]                    rsp_compare_value,
   output logic                           rsp_load_seconds,
   output logic [31:0]                    rsp_new_seconds
);

   import bcd_pkg::*;

   op_type        op;
   dp_status_type status;

   bcd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .op       (op)
   );

   bcd_dp #(.AVG_DEPTH(AVG_DEPTH)) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .op                    (op),
      .status                (status),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_time_bytes        (req_time_bytes),
      .req_crc_received      (req_crc_received),
      .req_capture_ticks     (req_capture_ticks),
      .req_local_seconds     (req_local_seconds),
      .req_second_start_ticks(req_second_start_ticks),
      .rsp_accepted          (rsp_accepted),
      .rsp_bad_stamp         (rsp_bad_stamp),
      .rsp_phase_offset      (rsp_phase_offset),
      .rsp_nominal_period    (rsp_nominal_period),
      .rsp_average_period    (rsp_average_period),
      .rsp_timer_period      (rsp_timer_period),
      .rsp_start_compare     (rsp_start_compare),
      .rsp_counter_reset     (rsp_counter_reset),
      .rsp_compare_value     (rsp_compare_value),
      .rsp_load_seconds      (rsp_load_seconds),
      .rsp_new_seconds       (rsp_new_seconds)
   );

   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |->
         (!rsp_start_compare && !rsp_counter_reset && !rsp_load_seconds
          && rsp_bad_stamp == BAD_NONE))
      else $error("rejected request carries commands");

   a_reset_loads: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_counter_reset) |-> (rsp_load_seconds && !rsp_start_compare))
      else $error("counter reset without second load");

   a_first_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_start_compare) |->
         (rsp_bad_stamp == BAD_NONE && rsp_phase_offset == 32'sd0 && rsp_load_seconds))
      else $error("first beacon result not clean");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is in work");

endmodule

`default_nettype wire
